### rtl/core/bcst_pkg.sv
// shared types, codes and helpers for the battery charge state tracker
`timescale 1ns / 1ps

package bcst_pkg;

  localparam int unsigned StateCodeBits = 3;
  localparam int unsigned CfgIdxBits    = 3;

  typedef logic [StateCodeBits-1:0] state_code_t;

  localparam state_code_t CodeNormal   = 3'd0;
  localparam state_code_t CodeWarning  = 3'd1;
  localparam state_code_t CodeEmpty    = 3'd2;
  localparam state_code_t CodeCharging = 3'd3;
  localparam state_code_t CodeFull     = 3'd4;

  typedef enum logic [4:0] {
    StNormal   = 5'b00001,
    StWarning  = 5'b00010,
    StEmpty    = 5'b00100,
    StCharging = 5'b01000,
    StFull     = 5'b10000
  } charge_state_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgWarningLevel = 3'd0,
    CfgSafeLevel    = 3'd1,
    CfgFullLevel    = 3'd2,
    CfgMiddleLevel  = 3'd3,
    CfgEmptySeconds = 3'd4,
    CfgFullSeconds  = 3'd5,
    CfgStartLevel   = 3'd6
  } cfg_idx_e;

  function automatic state_code_t state_code(charge_state_e st);
    state_code_t code;
    unique case (st)
      StNormal:   code = CodeNormal;
      StWarning:  code = CodeWarning;
      StEmpty:    code = CodeEmpty;
      StCharging: code = CodeCharging;
      StFull:     code = CodeFull;
      default:    code = CodeNormal;
    endcase
    return code;
  endfunction

endpackage

### rtl/core/bcst_cfg.sv
// configuration register file for the battery charge state tracker
`timescale 1ns / 1ps

module bcst_cfg #(
  parameter int unsigned LEVEL_BITS = 10,
  parameter int unsigned TIMER_BITS = 16,
  parameter int unsigned DATA_BITS  = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bcst_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [DATA_BITS-1:0]           cfg_wdata_i,
  output logic [LEVEL_BITS-1:0]          warning_level_o,
  output logic [LEVEL_BITS-1:0]          safe_level_o,
  output logic [LEVEL_BITS-1:0]          full_level_o,
  output logic [LEVEL_BITS-1:0]          middle_level_o,
  output logic [TIMER_BITS-1:0]          empty_seconds_o,
  output logic [TIMER_BITS-1:0]          full_seconds_o,
  output logic [LEVEL_BITS-1:0]          start_level_o,
  output logic                           start_wr_o
);

  localparam logic [LEVEL_BITS-1:0] FullLevelRst = LEVEL_BITS'(1023);
  localparam logic [TIMER_BITS-1:0] SecondsRst   = TIMER_BITS'(60);

  logic [LEVEL_BITS-1:0] warning_level_q, safe_level_q, full_level_q;
  logic [LEVEL_BITS-1:0] middle_level_q, start_level_q;
  logic [TIMER_BITS-1:0] empty_seconds_q, full_seconds_q;
  logic [LEVEL_BITS-1:0] wr_level;
  logic [TIMER_BITS-1:0] wr_timer;

  assign wr_level = cfg_wdata_i[LEVEL_BITS-1:0];
  assign wr_timer = cfg_wdata_i[TIMER_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warning_level_q <= '0;
      safe_level_q    <= '0;
      full_level_q    <= FullLevelRst;
      middle_level_q  <= '0;
      empty_seconds_q <= SecondsRst;
      full_seconds_q  <= SecondsRst;
      start_level_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (bcst_pkg::cfg_idx_e'(cfg_idx_i))
        bcst_pkg::CfgWarningLevel: warning_level_q <= wr_level;
        bcst_pkg::CfgSafeLevel:    safe_level_q    <= wr_level;
        bcst_pkg::CfgFullLevel:    full_level_q    <= wr_level;
        bcst_pkg::CfgMiddleLevel:  middle_level_q  <= wr_level;
        bcst_pkg::CfgEmptySeconds: empty_seconds_q <= wr_timer;
        bcst_pkg::CfgFullSeconds:  full_seconds_q  <= wr_timer;
        bcst_pkg::CfgStartLevel:   start_level_q   <= wr_level;
        default: ;
      endcase
    end
  end

  assign start_wr_o      = cfg_we_i && (cfg_idx_i == bcst_pkg::CfgStartLevel);
  assign warning_level_o = warning_level_q;
  assign safe_level_o    = safe_level_q;
  assign full_level_o    = full_level_q;
  assign middle_level_o  = middle_level_q;
  assign empty_seconds_o = empty_seconds_q;
  assign full_seconds_o  = full_seconds_q;
  assign start_level_o   = start_level_q;

endmodule

### rtl/core/bcst_core.sv
// charge state, second counters and health arming with their update logic
`timescale 1ns / 1ps

module bcst_core #(
  parameter int unsigned LEVEL_BITS = 10,
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  logic                      second_elapsed_i,
  input  logic                      connected_i,
  input  logic [LEVEL_BITS-1:0]     battery_level_i,
  input  logic [LEVEL_BITS-1:0]     warning_level_i,
  input  logic [LEVEL_BITS-1:0]     safe_level_i,
  input  logic [LEVEL_BITS-1:0]     full_level_i,
  input  logic [LEVEL_BITS-1:0]     middle_level_i,
  input  logic [TIMER_BITS-1:0]     empty_seconds_i,
  input  logic [TIMER_BITS-1:0]     full_seconds_i,
  input  logic [LEVEL_BITS-1:0]     start_level_i,
  input  logic                      start_wr_i,
  output bcst_pkg::state_code_t     battery_state_o,
  output logic                      count_health_o
);

  localparam logic [TIMER_BITS-1:0] TimerMax = '1;

  bcst_pkg::charge_state_e state_q, state_d;
  logic [TIMER_BITS-1:0]   low_cnt_q, low_cnt_d;
  logic [TIMER_BITS-1:0]   full_cnt_q, full_cnt_d;
  logic                    armed_q, armed_d;
  logic                    health;

  always_comb begin
    logic [TIMER_BITS-1:0] fc;
    state_d    = state_q;
    low_cnt_d  = low_cnt_q;
    full_cnt_d = full_cnt_q;
    armed_d    = armed_q;
    health     = 1'b0;
    fc         = full_cnt_q;
    if (second_elapsed_i) begin
      if (!connected_i) begin
        state_d = (battery_level_i < warning_level_i) ? bcst_pkg::StWarning
                                                      : bcst_pkg::StNormal;
        if (battery_level_i < safe_level_i) begin
          low_cnt_d = (low_cnt_q < empty_seconds_i) ? low_cnt_q + 1'b1 : low_cnt_q;
          if (low_cnt_d >= empty_seconds_i) begin
            state_d = bcst_pkg::StEmpty;
          end
        end else begin
          low_cnt_d = '0;
        end
        full_cnt_d = '0;
      end else begin
        low_cnt_d = '0;
        if (state_q != bcst_pkg::StCharging && state_q != bcst_pkg::StFull) begin
          state_d = bcst_pkg::StCharging;
          fc      = '0;
        end
        if (state_d != bcst_pkg::StFull && battery_level_i > full_level_i) begin
          if (fc != TimerMax) begin
            fc = fc + 1'b1;
          end
          if (fc >= full_seconds_i) begin
            state_d = bcst_pkg::StFull;
            if (armed_q && start_level_i != '0 && start_level_i < middle_level_i) begin
              health  = 1'b1;
              armed_d = 1'b0;
            end
          end
        end
        full_cnt_d = fc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= bcst_pkg::StNormal;
      low_cnt_q  <= '0;
      full_cnt_q <= '0;
      armed_q    <= 1'b1;
    end else begin
      if (fire_i) begin
        state_q    <= state_d;
        low_cnt_q  <= low_cnt_d;
        full_cnt_q <= full_cnt_d;
      end
      if (start_wr_i) begin
        armed_q <= 1'b1;
      end else if (fire_i) begin
        armed_q <= armed_d;
      end
    end
  end

  assign battery_state_o = bcst_pkg::state_code(state_d);
  assign count_health_o  = health;

endmodule

### rtl/core/battery_charge_state_tracker.sv
// top level of the battery charge state tracker
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o second_elapsed, connected, battery_level
//   out      output     out_valid_o / out_stall_i battery_state, count_health
//   cfg      input      cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// one item per cycle sustained unless out_stall_i holds a valid result in the output register
// the input register feeds the state update, whose result lands in the output register
// reset clears both valid flags, the charge state, counters and loads register defaults
// out_stall_i holds the output register; the input register still takes one more item
// and in_stall_o rises only when both registers are full
`timescale 1ns / 1ps

module battery_charge_state_tracker #(
  parameter int unsigned LEVEL_BITS = 10,
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            second_elapsed_i,
  input  logic                            connected_i,
  input  logic [LEVEL_BITS-1:0]           battery_level_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bcst_pkg::StateCodeBits-1:0] battery_state_o,
  output logic                            count_health_o,
  input  logic                            cfg_we_i,
  input  logic [bcst_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [((LEVEL_BITS > TIMER_BITS) ? LEVEL_BITS : TIMER_BITS)-1:0] cfg_wdata_i
);

  localparam int unsigned DataBits = (LEVEL_BITS > TIMER_BITS) ? LEVEL_BITS : TIMER_BITS;

  logic                  in_valid_q;
  logic                  tick_q, conn_q;
  logic [LEVEL_BITS-1:0] level_q;
  logic                  out_valid_q;
  bcst_pkg::state_code_t state_out_q;
  logic                  health_out_q;
  logic                  out_free, in_take, fire;

  logic [LEVEL_BITS-1:0] warning_level, safe_level, full_level, middle_level, start_level;
  logic [TIMER_BITS-1:0] empty_seconds, full_seconds;
  logic                  start_wr;
  bcst_pkg::state_code_t state_code;
  logic                  health;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      tick_q  <= second_elapsed_i;
      conn_q  <= connected_i;
      level_q <= battery_level_i;
    end
    if (fire) begin
      state_out_q  <= state_code;
      health_out_q <= health;
    end
  end

  bcst_cfg #(
    .LEVEL_BITS(LEVEL_BITS),
    .TIMER_BITS(TIMER_BITS),
    .DATA_BITS (DataBits)
  ) u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .warning_level_o(warning_level),
    .safe_level_o   (safe_level),
    .full_level_o   (full_level),
    .middle_level_o (middle_level),
    .empty_seconds_o(empty_seconds),
    .full_seconds_o (full_seconds),
    .start_level_o  (start_level),
    .start_wr_o     (start_wr)
  );

  bcst_core #(
    .LEVEL_BITS(LEVEL_BITS),
    .TIMER_BITS(TIMER_BITS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (fire),
    .second_elapsed_i(tick_q),
    .connected_i     (conn_q),
    .battery_level_i (level_q),
    .warning_level_i (warning_level),
    .safe_level_i    (safe_level),
    .full_level_i    (full_level),
    .middle_level_i  (middle_level),
    .empty_seconds_i (empty_seconds),
    .full_seconds_i  (full_seconds),
    .start_level_i   (start_level),
    .start_wr_i      (start_wr),
    .battery_state_o (state_code),
    .count_health_o  (health)
  );

  assign out_valid_o     = out_valid_q;
  assign battery_state_o = state_out_q;
  assign count_health_o  = health_out_q;

endmodule

### rtl/core/bcst_checker.sv
// port-level checks for the battery charge state tracker and their bind
`timescale 1ns / 1ps

module bcst_checker #(
  parameter int unsigned LEVEL_BITS = 10,
  parameter int unsigned TIMER_BITS = 16
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               second_elapsed_i,
  input logic                               connected_i,
  input logic [LEVEL_BITS-1:0]              battery_level_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [bcst_pkg::StateCodeBits-1:0] battery_state_o,
  input logic                               count_health_o,
  input logic                               cfg_we_i,
  input logic [bcst_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input logic [((LEVEL_BITS > TIMER_BITS) ? LEVEL_BITS : TIMER_BITS)-1:0] cfg_wdata_i
);

  // health item is only ever reported together with full
  a_health_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && count_health_o |-> battery_state_o == bcst_pkg::CodeFull)
    else $error("health item without full state");

  // reported state stays within the defined codes
  a_state_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> battery_state_o == bcst_pkg::CodeNormal
                 || battery_state_o == bcst_pkg::CodeWarning
                 || battery_state_o == bcst_pkg::CodeEmpty
                 || battery_state_o == bcst_pkg::CodeCharging
                 || battery_state_o == bcst_pkg::CodeFull)
    else $error("undefined state code");

  // input backs up only when the output side holds an item
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(battery_state_o)
                                   && $stable(count_health_o))
    else $error("stalled result item changed");

endmodule

bind battery_charge_state_tracker bcst_checker #(
  .LEVEL_BITS(LEVEL_BITS),
  .TIMER_BITS(TIMER_BITS)
) u_bcst_checker (.*);

### tb/tb_top.sv
// self-checking testbench for the battery charge state tracker
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned LevelW = 10;
  localparam int unsigned TimerW = 16;
  localparam int unsigned DataW  = (LevelW > TimerW) ? LevelW : TimerW;
  localparam logic [bcst_pkg::CfgIdxBits-1:0] CfgNoReg = 3'd7;

  typedef struct {
    logic              tick;
    logic              powered;
    logic [LevelW-1:0] level;
  } loop_pass_t;

  typedef struct {
    bcst_pkg::state_code_t state;
    logic                  health;
  } charge_report_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            second_elapsed = 1'b0;
  logic                            connected = 1'b0;
  logic [LevelW-1:0]               battery_level = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  bcst_pkg::state_code_t           battery_state;
  logic                            count_health;
  logic                            cfg_we = 1'b0;
  logic [bcst_pkg::CfgIdxBits-1:0] cfg_idx = '0;
  logic [DataW-1:0]                cfg_wdata = '0;

  // predictor copy of the registers and state
  logic [LevelW-1:0]     warn_lvl, safe_lvl, full_lvl, middle_lvl, start_lvl;
  logic [TimerW-1:0]     empty_lim, full_lim;
  bcst_pkg::state_code_t trk_state;
  logic [TimerW-1:0]     low_secs, full_secs;
  logic                  health_armed;

  loop_pass_t     pending_passes[$];
  charge_report_t expected_reports[$];

  int  err_count = 0;
  bit  pass_taken = 1'b0;
  int  gap_max = 0, burst_max = 1, stall_pct = 0;
  int  gap_left = 0, burst_left = 0;
  int  hold_req = 0, hold_left = 0;

  battery_charge_state_tracker u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .second_elapsed_i (second_elapsed),
    .connected_i      (connected),
    .battery_level_i  (battery_level),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .battery_state_o  (battery_state),
    .count_health_o   (count_health),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void flag_error(string what);
    err_count++;
    if (err_count <= 10) begin
      $display("%0t: %s", $time, what);
    end
  endfunction

  function automatic void predict_charge(input logic tick, input logic powered,
                                         input logic [LevelW-1:0] level,
                                         output charge_report_t res);
    res.health = 1'b0;
    if (tick) begin
      if (!powered) begin
        trk_state = bcst_pkg::CodeNormal;
        if (level < warn_lvl) trk_state = bcst_pkg::CodeWarning;
        if (level < safe_lvl) begin
          if (low_secs < empty_lim) low_secs++;
          if (low_secs >= empty_lim) trk_state = bcst_pkg::CodeEmpty;
        end else begin
          low_secs = '0;
        end
        full_secs = '0;
      end else begin
        low_secs = '0;
        if (trk_state != bcst_pkg::CodeCharging && trk_state != bcst_pkg::CodeFull) begin
          trk_state = bcst_pkg::CodeCharging;
          full_secs = '0;
        end
        if (trk_state != bcst_pkg::CodeFull && level > full_lvl) begin
          if (full_secs != '1) full_secs++;
          if (full_secs >= full_lim) begin
            trk_state = bcst_pkg::CodeFull;
            if (health_armed && start_lvl != '0 && start_lvl < middle_lvl) begin
              res.health = 1'b1;
              health_armed = 1'b0;
            end
          end
        end
      end
    end
    res.state = trk_state;
  endfunction

  function automatic void queue_pass(logic tick, logic powered, logic [LevelW-1:0] level);
    loop_pass_t p;
    p.tick = tick;
    p.powered = powered;
    p.level = level;
    pending_passes.push_back(p);
  endfunction

  function automatic logic [DataW-1:0] level_word(int unsigned lvl);
    return {6'($urandom_range(63)), LevelW'(lvl)};
  endfunction

  function automatic logic [LevelW-1:0] level_below(logic [LevelW-1:0] thr);
    return (thr == '0) ? '0 : LevelW'($urandom_range(0, thr - 1));
  endfunction

  function automatic logic [LevelW-1:0] level_above(logic [LevelW-1:0] thr);
    return (thr == '1) ? '1 : LevelW'($urandom_range(thr + 1, 1023));
  endfunction

  // sender: bursts of items with random gaps, payload held while stalled
  always @(negedge clk_i) begin : sender
    loop_pass_t nxt;
    logic drive;
    if (rst_ni && !(in_valid && !pass_taken)) begin
      drive = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
      end else if (pending_passes.size() != 0) begin
        nxt = pending_passes.pop_front();
        drive = 1'b1;
        second_elapsed <= nxt.tick;
        connected <= nxt.powered;
        battery_level <= nxt.level;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, burst_max);
          gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        end else begin
          burst_left--;
        end
      end
      in_valid <= drive;
    end
  end

  // receiver: random stall pattern plus long hold-off on request
  always @(negedge clk_i) begin : receiver
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin : monitor
    charge_report_t want;
    pass_taken = 1'b0;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          flag_error($sformatf("unexpected item: state %0d health %0b",
                               battery_state, count_health));
        end else begin
          want = expected_reports.pop_front();
          if (want.state !== battery_state || want.health !== count_health) begin
            flag_error($sformatf("mismatch: state exp %0d got %0d, health exp %0b got %0b",
                                 want.state, battery_state, want.health, count_health));
          end
        end
      end
      pass_taken = in_valid && !in_stall;
      if (pass_taken) begin
        predict_charge(second_elapsed, connected, battery_level, want);
        expected_reports.push_back(want);
      end
    end
  end

  task automatic write_reg(input logic [bcst_pkg::CfgIdxBits-1:0] idx,
                           input logic [DataW-1:0] data);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      bcst_pkg::CfgWarningLevel: warn_lvl = data[LevelW-1:0];
      bcst_pkg::CfgSafeLevel:    safe_lvl = data[LevelW-1:0];
      bcst_pkg::CfgFullLevel:    full_lvl = data[LevelW-1:0];
      bcst_pkg::CfgMiddleLevel:  middle_lvl = data[LevelW-1:0];
      bcst_pkg::CfgEmptySeconds: empty_lim = data[TimerW-1:0];
      bcst_pkg::CfgFullSeconds:  full_lim = data[TimerW-1:0];
      bcst_pkg::CfgStartLevel: begin
        start_lvl = data[LevelW-1:0];
        health_armed = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic load_limits(logic [DataW-1:0] warn, logic [DataW-1:0] safe,
                             logic [DataW-1:0] full, logic [DataW-1:0] middle,
                             logic [DataW-1:0] empty_s, logic [DataW-1:0] full_s,
                             logic [DataW-1:0] start);
    write_reg(bcst_pkg::CfgWarningLevel, warn);
    write_reg(bcst_pkg::CfgSafeLevel, safe);
    write_reg(bcst_pkg::CfgFullLevel, full);
    write_reg(bcst_pkg::CfgMiddleLevel, middle);
    write_reg(bcst_pkg::CfgEmptySeconds, empty_s);
    write_reg(bcst_pkg::CfgFullSeconds, full_s);
    write_reg(bcst_pkg::CfgStartLevel, start);
    write_reg(CfgNoReg, DataW'($urandom_range(65535)));
  endtask

  task automatic wait_drained();
    while (pending_passes.size() != 0 || in_valid || expected_reports.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // mostly well-formed discharge and charge runs, some noise
  task automatic make_passes(int n);
    int made;
    int kind;
    int run;
    logic tick;
    logic [LevelW-1:0] lvl;
    made = 0;
    while (made < n) begin
      kind = $urandom_range(9);
      run = $urandom_range(1, 8);
      for (int k = 0; k < run && made < n; k++) begin
        tick = ($urandom_range(9) != 0);
        if (kind < 4) begin
          case ($urandom_range(3))
            0: lvl = LevelW'($urandom_range(1023));
            1: lvl = level_below(warn_lvl);
            default: lvl = level_below(safe_lvl);
          endcase
          queue_pass(tick, 1'b0, lvl);
        end else if (kind < 8) begin
          lvl = ($urandom_range(3) != 0) ? level_above(full_lvl) :
                                           LevelW'($urandom_range(1023));
          queue_pass(tick, 1'b1, lvl);
        end else begin
          queue_pass(1'($urandom_range(1)), 1'($urandom_range(1)),
                     LevelW'($urandom_range(1023)));
        end
        made++;
      end
    end
  endtask

  initial begin
    int unsigned mid;
    logic [DataW-1:0] es, fs;
    warn_lvl = '0;
    safe_lvl = '0;
    full_lvl = 10'd1023;
    middle_lvl = '0;
    empty_lim = 16'd60;
    full_lim = 16'd60;
    start_lvl = '0;
    trk_state = bcst_pkg::CodeNormal;
    low_secs = '0;
    full_secs = '0;
    health_armed = 1'b1;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults, no tick, level extremes
    queue_pass(1'b0, 1'b0, 10'd0);
    queue_pass(1'b0, 1'b1, 10'd1023);
    queue_pass(1'b1, 1'b0, 10'd0);
    queue_pass(1'b1, 1'b0, 10'd1023);
    queue_pass(1'b1, 1'b1, 10'd1023);
    queue_pass(1'b1, 1'b1, 10'd0);
    queue_pass(1'b0, 1'b0, 10'd512);
    queue_pass(1'b1, 1'b0, 10'd341);
    wait_drained();

    // zero second limits, health pulse once
    gap_max = 3;
    burst_max = 4;
    stall_pct = 30;
    load_limits(level_word(500), level_word(300), level_word(800), level_word(600),
                16'd0, 16'd0, level_word(100));
    queue_pass(1'b1, 1'b0, 10'd200);
    queue_pass(1'b1, 1'b0, 10'd400);
    queue_pass(1'b1, 1'b0, 10'd900);
    queue_pass(1'b1, 1'b1, 10'd900);
    queue_pass(1'b1, 1'b1, 10'd900);
    queue_pass(1'b0, 1'b0, 10'd100);
    queue_pass(1'b1, 1'b0, 10'd900);
    queue_pass(1'b1, 1'b1, 10'd1023);
    wait_drained();

    // low count stops at its limit, start level rewrite re-arms health
    load_limits(level_word(500), level_word(300), level_word(800), level_word(600),
                16'd3, 16'd2, level_word(100));
    repeat (4) queue_pass(1'b1, 1'b0, 10'd100);
    repeat (3) queue_pass(1'b1, 1'b1, 10'd1000);
    queue_pass(1'b1, 1'b1, 10'd0);
    queue_pass(1'b0, 1'b1, 10'd0);
    wait_drained();

    for (int p = 0; p < 10; p++) begin
      if (p == 0) begin
        load_limits('0, '0, '0, '0, '0, '0, '0);
      end else if (p == 1) begin
        load_limits('1, '1, '1, '1, '1, '1, '1);
      end else begin
        mid = $urandom_range(2, 1023);
        es = ($urandom_range(7) == 0) ? DataW'($urandom_range(65535)) :
                                        DataW'($urandom_range(0, 5));
        fs = ($urandom_range(7) == 0) ? DataW'($urandom_range(65535)) :
                                        DataW'($urandom_range(0, 5));
        load_limits(level_word($urandom_range(1023)), level_word($urandom_range(1023)),
                    level_word($urandom_range(1023)), level_word(mid), es, fs,
                    level_word(($urandom_range(3) != 0) ? $urandom_range(1, mid - 1) :
                                                          $urandom_range(1023)));
      end
      if (p % 3 == 0 || p == 4) begin
        gap_max = 0;
        burst_max = 1;
        stall_pct = 0;
      end else begin
        gap_max = $urandom_range(1, 6);
        burst_max = $urandom_range(1, 10);
        stall_pct = $urandom_range(10, 60);
      end
      make_passes(75);
      if (p == 4) begin
        @(posedge clk_i);
        hold_req = 80;
      end
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (expected_reports.size() != 0) begin
      flag_error("items still expected at end of run");
    end
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

### files.f
rtl/core/bcst_pkg.sv
rtl/core/bcst_cfg.sv
rtl/core/bcst_core.sv
rtl/core/battery_charge_state_tracker.sv
rtl/core/bcst_checker.sv
tb/tb_top.sv
